// ===== rtl/core/ime_pkg.sv =====
package ime_pkg;

  // Request types of an input item.
  localparam logic [1:0] REQ_EVENT   = 2'd0;
  localparam logic [1:0] REQ_RESTART = 2'd1;
  localparam logic [1:0] REQ_FINISH  = 2'd2;

  // Recorded event kinds.
  localparam logic [2:0] KIND_MOVE_ABS    = 3'd0;
  localparam logic [2:0] KIND_MOVE_REL    = 3'd1;
  localparam logic [2:0] KIND_BTN_PRESS   = 3'd2;
  localparam logic [2:0] KIND_BTN_RELEASE = 3'd3;
  localparam logic [2:0] KIND_KEY_PRESS   = 3'd4;
  localparam logic [2:0] KIND_KEY_RELEASE = 3'd5;
  localparam logic [2:0] KIND_SCROLL      = 3'd6;
  localparam logic [2:0] KIND_UNKNOWN     = 3'd7;

  // Action codes of a result item.
  localparam logic [2:0] ACT_MOVE_ABS = 3'd0;
  localparam logic [2:0] ACT_MOVE_REL = 3'd1;
  localparam logic [2:0] ACT_BUTTON   = 3'd2;
  localparam logic [2:0] ACT_KEY      = 3'd3;
  localparam logic [2:0] ACT_SCROLL   = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_SPEED = 3'd0;
  localparam logic [2:0] REG_REC_W = 3'd1;
  localparam logic [2:0] REG_REC_H = 3'd2;
  localparam logic [2:0] REG_TGT_W = 3'd3;
  localparam logic [2:0] REG_TGT_H = 3'd4;

  localparam logic [13:0] SPEED_DEFAULT = 14'd100;
  localparam int DIV_W  = 56;
  localparam int DVS_W  = 16;

  typedef enum logic [1:0] {
    OP_EVENT   = 2'd0,
    OP_RESTART = 2'd1,
    OP_FINISH  = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [2:0]         event_kind;
    logic [31:0]        gap_us;
    logic [15:0]        input_code;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [15:0]        out_code;
    logic               is_press;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic [47:0]        due_us;
    logic               last;
  } out_item_t;

  // Classified item passed from the front to the back.
  typedef struct packed {
    op_t                op;
    logic [2:0]         action;
    logic               emit;
    logic               track;
    logic               sel_btn;
    logic               press;
    logic               is_abs;
    logic [15:0]        code;
    logic [31:0]        delay;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } q_item_t;

  typedef struct packed {
    logic [13:0] speed;
    logic [15:0] rec_w;
    logic [15:0] rec_h;
    logic [15:0] tgt_w;
    logic [15:0] tgt_h;
  } cfg_t;

endpackage

// ===== rtl/core/ime_queue.sv =====
module ime_queue
  import ime_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_data,
  input  logic    pop,
  output q_item_t head,
  output logic    empty,
  output logic    full
);

  q_item_t    ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign head  = ent_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/core/ime_front.sv =====
module ime_front
  import ime_pkg::*;
(
  input  in_item_t in_data,
  input  logic     start,
  input  logic     q_full,
  output logic     busy,
  output logic     push,
  output q_item_t  push_data
);

  assign busy = q_full;
  assign push = start && !q_full;

  // Classify the item into an operation and its emit and tracking flags.
  always_comb begin
    push_data         = '0;
    push_data.delay   = in_data.gap_us;
    push_data.code    = in_data.input_code;
    push_data.x       = in_data.pos_x;
    push_data.y       = in_data.pos_y;
    case (in_data.req_type)
      REQ_EVENT:   push_data.op = OP_EVENT;
      REQ_RESTART: push_data.op = OP_RESTART;
      REQ_FINISH:  push_data.op = OP_FINISH;
      default:     push_data.op = OP_NONE;
    endcase
    case (in_data.event_kind)
      KIND_MOVE_ABS: begin
        push_data.action = ACT_MOVE_ABS;
        push_data.emit   = 1'b1;
        push_data.is_abs = 1'b1;
      end
      KIND_MOVE_REL: begin
        push_data.action = ACT_MOVE_REL;
        push_data.emit   = (in_data.pos_x != 32'sd0) || (in_data.pos_y != 32'sd0);
      end
      KIND_BTN_PRESS, KIND_BTN_RELEASE: begin
        push_data.action  = ACT_BUTTON;
        push_data.emit    = 1'b1;
        push_data.track   = 1'b1;
        push_data.sel_btn = 1'b1;
        push_data.press   = (in_data.event_kind == KIND_BTN_PRESS);
      end
      KIND_KEY_PRESS, KIND_KEY_RELEASE: begin
        push_data.action = ACT_KEY;
        push_data.emit   = 1'b1;
        push_data.track  = 1'b1;
        push_data.press  = (in_data.event_kind == KIND_KEY_PRESS);
      end
      KIND_SCROLL: begin
        push_data.action = ACT_SCROLL;
        push_data.emit   = 1'b1;
      end
      default: begin
        push_data.emit = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/ime_div.sv =====
module ime_div
  import ime_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CW = $clog2(DIV_W);

  logic             run_r;
  logic [CW-1:0]    cnt_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r;
  logic [DIV_W-1:0] quo_r;
  logic             done_r;
  logic [DVS_W:0]   trial;
  logic             fits;

  // One quotient bit per cycle, restoring.
  assign trial    = {rem_r, quo_r[DIV_W-1]};
  assign fits     = (trial >= {1'b0, dvs_r});
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      dvs_r <= divisor;
      rem_r <= '0;
      quo_r <= dividend;
    end else if (run_r) begin
      rem_r <= fits ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(DIV_W - 1);
      end else if (run_r) begin
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/ime_back.sv =====
module ime_back
  import ime_pkg::*;
#(
  parameter int HELD_CAP = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_empty,
  input  q_item_t   q_head,
  output logic      pop,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int IW = (HELD_CAP > 1) ? $clog2(HELD_CAP) : 1;
  localparam int CW = $clog2(HELD_CAP + 1);

  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_TIME   = 13'b0000000000010,
    ST_TDIV   = 13'b0000000000100,
    ST_MUL    = 13'b0000000001000,
    ST_SSTART = 13'b0000000010000,
    ST_SDIV   = 13'b0000000100000,
    ST_EMIT   = 13'b0000001000000,
    ST_RD     = 13'b0000010000000,
    ST_CMP    = 13'b0000100000000,
    ST_MVWR   = 13'b0001000000000,
    ST_FRD    = 13'b0010000000000,
    ST_FOUT   = 13'b0100000000000,
    ST_TSTART = 13'b1000000000000
  } state_t;

  state_t             state_r, state_nxt;
  q_item_t            item_r, item_nxt;
  logic [47:0]        vt_r, vt_nxt;
  logic [47:0]        due_r, due_nxt;
  logic signed [31:0] x_r, x_nxt;
  logic signed [31:0] y_r, y_nxt;
  logic               axis_r, axis_nxt;
  logic signed [48:0] prod_r, prod_nxt;
  logic [CW-1:0]      kcnt_r, kcnt_nxt;
  logic [CW-1:0]      bcnt_r, bcnt_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic               sel_r, sel_nxt;
  logic               ov_r, ov_nxt;
  out_item_t          out_r, out_nxt;

  logic [15:0]        key_mem [HELD_CAP];
  logic [15:0]        btn_mem [HELD_CAP];
  logic [15:0]        key_q, btn_q, rdata;
  logic               rd_en, wr_en;
  logic [IW-1:0]      rd_addr, wr_addr;
  logic [15:0]        wr_data;

  logic               div_start, div_done;
  logic [DIV_W-1:0]   div_dividend, div_quo;
  logic [DVS_W-1:0]   div_divisor;

  logic [48:0]        vt_sum;
  logic [54:0]        vt_x100;
  logic [15:0]        speed_eff;
  logic               scale_on;
  logic [CW-1:0]      cur_cnt;
  logic [48:0]        prod_mag;
  logic [31:0]        sq;
  logic signed [48:0] mul_a, mul_b;

  ime_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign out_valid = ov_r;
  assign out_data  = out_r;

  // Held-code stores, one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en && !sel_r) begin
      key_mem[wr_addr] <= wr_data;
    end
    if (wr_en && sel_r) begin
      btn_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      key_q <= key_mem[rd_addr];
      btn_q <= btn_mem[rd_addr];
    end
  end

  // Time, scaling and datapath helpers.
  always_comb begin
    vt_sum    = {1'b0, vt_r} + {17'd0, item_r.delay};
    vt_x100   = ({7'd0, vt_r} << 6) + ({7'd0, vt_r} << 5) + ({7'd0, vt_r} << 2);
    speed_eff = {2'd0, (cfg.speed == 14'd0) ? SPEED_DEFAULT : cfg.speed};
    scale_on  = (cfg.tgt_w != 16'd0) && (cfg.tgt_h != 16'd0) &&
                (cfg.rec_w != 16'd0) && (cfg.rec_h != 16'd0) &&
                ((cfg.tgt_w != cfg.rec_w) || (cfg.tgt_h != cfg.rec_h));
    cur_cnt   = sel_r ? bcnt_r : kcnt_r;
    rdata     = sel_r ? btn_q : key_q;
    prod_mag  = prod_r[48] ? 49'(-prod_r) : 49'(prod_r);
    sq        = prod_r[48] ? 32'(-div_quo[31:0]) : div_quo[31:0];
    mul_a     = axis_r ? 49'(y_r) : 49'(x_r);
    mul_b     = {33'd0, axis_r ? cfg.tgt_h : cfg.tgt_w};
  end

  // Sequencer.
  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    vt_nxt       = vt_r;
    due_nxt      = due_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    axis_nxt     = axis_r;
    prod_nxt     = prod_r;
    kcnt_nxt     = kcnt_r;
    bcnt_nxt     = bcnt_r;
    idx_nxt      = idx_r;
    sel_nxt      = sel_r;
    ov_nxt       = 1'b0;
    out_nxt      = out_r;
    pop          = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = idx_r[IW-1:0];
    wr_en        = 1'b0;
    wr_addr      = idx_r[IW-1:0];
    wr_data      = item_r.code;
    div_start    = 1'b0;
    div_dividend = {1'b0, vt_x100};
    div_divisor  = speed_eff;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          pop      = 1'b1;
          item_nxt = q_head;
          sel_nxt  = q_head.sel_btn;
          case (q_head.op)
            OP_EVENT: begin
              state_nxt = ST_TIME;
            end
            OP_RESTART: begin
              vt_nxt = '0;
            end
            OP_FINISH: begin
              if (kcnt_r != '0) begin
                sel_nxt   = 1'b0;
                idx_nxt   = kcnt_r - 1'b1;
                state_nxt = ST_FRD;
              end else if (bcnt_r != '0) begin
                sel_nxt   = 1'b1;
                idx_nxt   = bcnt_r - 1'b1;
                state_nxt = ST_FRD;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_TIME: begin
        // Saturating accumulate of the recorded delay.
        vt_nxt    = vt_sum[48] ? '1 : vt_sum[47:0];
        state_nxt = ST_TSTART;
      end
      ST_TSTART: begin
        // Due time is the updated virtual time times 100 over the speed.
        div_start = 1'b1;
        state_nxt = ST_TDIV;
      end
      ST_TDIV: begin
        if (div_done) begin
          due_nxt = (div_quo[DIV_W-1:48] != '0) ? '1 : div_quo[47:0];
          x_nxt   = item_r.x;
          y_nxt   = item_r.y;
          if (!item_r.emit) begin
            state_nxt = ST_IDLE;
          end else if (item_r.is_abs && scale_on) begin
            axis_nxt  = 1'b0;
            state_nxt = ST_MUL;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_MUL: begin
        prod_nxt  = 49'(mul_a * mul_b);
        state_nxt = ST_SSTART;
      end
      ST_SSTART: begin
        div_start    = 1'b1;
        div_dividend = {7'd0, prod_mag};
        div_divisor  = axis_r ? cfg.rec_h : cfg.rec_w;
        state_nxt    = ST_SDIV;
      end
      ST_SDIV: begin
        if (div_done) begin
          if (!axis_r) begin
            x_nxt     = sq;
            axis_nxt  = 1'b1;
            state_nxt = ST_MUL;
          end else begin
            y_nxt     = sq;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        ov_nxt           = 1'b1;
        out_nxt.action   = item_r.action;
        out_nxt.out_code = item_r.track ? item_r.code : 16'd0;
        out_nxt.is_press = item_r.track && item_r.press;
        out_nxt.out_x    = item_r.track ? 32'sd0 : x_r;
        out_nxt.out_y    = item_r.track ? 32'sd0 : y_r;
        out_nxt.due_us   = due_r;
        out_nxt.last     = 1'b1;
        idx_nxt          = '0;
        state_nxt        = item_r.track ? ST_RD : ST_IDLE;
      end
      ST_RD: begin
        if (idx_r == cur_cnt) begin
          // Code not held: a press appends it when there is room.
          if (item_r.press && (cur_cnt < CW'(HELD_CAP))) begin
            wr_en   = 1'b1;
            wr_addr = cur_cnt[IW-1:0];
            if (sel_r) begin
              bcnt_nxt = bcnt_r + 1'b1;
            end else begin
              kcnt_nxt = kcnt_r + 1'b1;
            end
          end
          state_nxt = ST_IDLE;
        end else begin
          rd_en     = 1'b1;
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (rdata == item_r.code) begin
          if (item_r.press) begin
            state_nxt = ST_IDLE;
          end else begin
            // Fetch the last entry to move into the freed slot.
            rd_en     = 1'b1;
            rd_addr   = IW'(cur_cnt - 1'b1);
            state_nxt = ST_MVWR;
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_MVWR: begin
        wr_en   = 1'b1;
        wr_data = rdata;
        if (sel_r) begin
          bcnt_nxt = bcnt_r - 1'b1;
        end else begin
          kcnt_nxt = kcnt_r - 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      ST_FRD: begin
        rd_en     = 1'b1;
        state_nxt = ST_FOUT;
      end
      ST_FOUT: begin
        ov_nxt           = 1'b1;
        out_nxt.action   = sel_r ? ACT_BUTTON : ACT_KEY;
        out_nxt.out_code = rdata;
        out_nxt.is_press = 1'b0;
        out_nxt.out_x    = 32'sd0;
        out_nxt.out_y    = 32'sd0;
        out_nxt.due_us   = '0;
        out_nxt.last     = (idx_r == '0) && (sel_r || (bcnt_r == '0));
        if (idx_r != '0) begin
          idx_nxt   = idx_r - 1'b1;
          state_nxt = ST_FRD;
        end else if (!sel_r && (bcnt_r != '0)) begin
          sel_nxt   = 1'b1;
          idx_nxt   = bcnt_r - 1'b1;
          state_nxt = ST_FRD;
        end else begin
          kcnt_nxt  = '0;
          bcnt_nxt  = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    due_r  <= due_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    prod_r <= prod_nxt;
    out_r  <= out_nxt;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      vt_r    <= '0;
      axis_r  <= 1'b0;
      kcnt_r  <= '0;
      bcnt_r  <= '0;
      idx_r   <= '0;
      sel_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vt_r    <= vt_nxt;
      axis_r  <= axis_nxt;
      kcnt_r  <= kcnt_nxt;
      bcnt_r  <= bcnt_nxt;
      idx_r   <= idx_nxt;
      sel_r   <= sel_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

// ===== rtl/core/input_macro_replay_engine_core.sv =====
// A timed event shows its result after the queue, the time accumulate, a divide by the speed
// and the output register; a rescaled absolute move adds a multiply and a divide per axis. A
// finish item shows one release per held key, then one per held button. The receiver cannot
// stall, so results never wait. The back end takes one item at a time and, after a key or
// button result, searches the held set; a two-entry queue takes new items meanwhile. rst_n is
// synchronous: control and configuration registers reset and both held sets empty.
module input_macro_replay_engine_core
  import ime_pkg::*;
#(
  parameter int HELD_CAP = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_data,
  output logic        out_valid,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg_r;
  logic    q_full, q_empty, push, pop;
  q_item_t push_data, q_head;
  logic    cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed <= SPEED_DEFAULT;
      cfg_r.rec_w <= '0;
      cfg_r.rec_h <= '0;
      cfg_r.tgt_w <= '0;
      cfg_r.tgt_h <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_SPEED: cfg_r.speed <= pwdata[13:0];
        REG_REC_W: cfg_r.rec_w <= pwdata[15:0];
        REG_REC_H: cfg_r.rec_h <= pwdata[15:0];
        REG_TGT_W: cfg_r.tgt_w <= pwdata[15:0];
        REG_TGT_H: cfg_r.tgt_h <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[4:2])
      REG_SPEED: prdata = {18'd0, cfg_r.speed};
      REG_REC_W: prdata = {16'd0, cfg_r.rec_w};
      REG_REC_H: prdata = {16'd0, cfg_r.rec_h};
      REG_TGT_W: prdata = {16'd0, cfg_r.tgt_w};
      REG_TGT_H: prdata = {16'd0, cfg_r.tgt_h};
      default:   prdata = '0;
    endcase
  end

  ime_front u_front (
    .in_data   (in_data),
    .start     (start),
    .q_full    (q_full),
    .busy      (busy),
    .push      (push),
    .push_data (push_data)
  );

  ime_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  ime_back #(
    .HELD_CAP (HELD_CAP)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/ime_checker.sv =====
module ime_checker
  import ime_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input out_item_t out_data,
  input logic      pready
);

  // No result leaves in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // The configuration port never waits.
  a_pready_high: assert property (@(posedge clk) pready)
    else $error("configuration port not ready");

  // Key and button results carry no coordinates.
  a_keybtn_xy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.action == ACT_KEY || out_data.action == ACT_BUTTON)
    |-> out_data.out_x == 32'sd0 && out_data.out_y == 32'sd0)
    else $error("key or button result with coordinates");

  // Move and scroll results carry no code and no press flag.
  a_move_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.action == ACT_MOVE_ABS || out_data.action == ACT_MOVE_REL ||
                  out_data.action == ACT_SCROLL)
    |-> out_data.out_code == 16'd0 && !out_data.is_press)
    else $error("move or scroll result with a code");

  // A relative move is never a zero move.
  a_rel_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.action == ACT_MOVE_REL
    |-> out_data.out_x != 32'sd0 || out_data.out_y != 32'sd0)
    else $error("zero relative move emitted");

endmodule

bind input_macro_replay_engine_core ime_checker u_ime_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_data  (out_data),
  .pready    (pready)
);
